>>> src/cmtd_pkg.sv
package cmtd_pkg;

    localparam int unsigned KindW   = 2;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned TokW    = 32;
    localparam int unsigned UsedW   = 3;
    localparam int unsigned ShiftW  = 2;
    localparam int unsigned InDataW = 8;
    localparam int unsigned OutDataW = 40;

    typedef enum logic [KindW-1:0] {
        CLS_TYPE   = 2'd0,
        CLS_STRING = 2'd1,
        CLS_FIELD  = 2'd2,
        CLS_NONE   = 2'd3
    } t_class;

    localparam logic [ByteW-1:0] LongByte   = 8'hFF;
    localparam logic [ByteW-1:0] ShortLimit = 8'hBF;
    localparam logic [ByteW-1:0] FieldMid   = 8'hDF;
    localparam logic [ByteW-1:0] MidLimit   = 8'hEF;
    localparam logic [ByteW-1:0] Off0      = 8'hC0;
    localparam logic [ByteW-1:0] Off1      = 8'hE0;
    localparam logic [ByteW-1:0] Off2      = 8'hF0;

    localparam logic [TokW-1:0] TypeBase0   = 32'h0200_0000;
    localparam logic [TokW-1:0] TypeBase1   = 32'h0100_0000;
    localparam logic [TokW-1:0] TypeBase2   = 32'h1B00_0000;
    localparam logic [TokW-1:0] StrBase0    = 32'h7000_0000;
    localparam logic [TokW-1:0] StrBase1    = 32'h7000_C000;
    localparam logic [TokW-1:0] FieldBase0  = 32'h0400_0000;
    localparam logic [TokW-1:0] FieldBase1  = 32'h0A00_0000;
    localparam logic [TokW-1:0] FieldBase3  = 32'h0A00_2000;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [TokW-1:0]  token;
        logic [KindW-1:0] token_class;
        logic [UsedW-1:0] bytes_used;
    } t_res;

    typedef struct packed {
        logic [TokW-1:0]  base;
        logic [UsedW-1:0] more;
    } t_start;

    function automatic logic [TokW-1:0] lo_byte(input logic [ByteW-1:0] v);
        return {16'h0000, v, 8'h00};
    endfunction

    function automatic logic [TokW-1:0] hi_byte(input logic [ByteW-1:0] v);
        return {8'h00, v, 16'h0000};
    endfunction

    // base value and count of following bytes for a first byte
    function automatic t_start start_decode(input t_class cls, input logic [ByteW-1:0] b);
        t_start s;
        s.more = 3'd1;
        s.base = '0;
        if (b == LongByte) begin
            s.more = 3'd4;
        end else begin
            case (cls)
                CLS_TYPE: begin
                    if (b <= ShortLimit) begin
                        s.base = TypeBase0 + lo_byte(b);
                    end else if (b <= MidLimit) begin
                        s.base = TypeBase1 + lo_byte(b - Off0);
                    end else begin
                        s.base = TypeBase2 + lo_byte(b - Off2);
                    end
                end
                CLS_STRING: begin
                    if (b <= ShortLimit) begin
                        s.base = StrBase0 + lo_byte(b);
                    end else begin
                        s.base = StrBase1 + hi_byte(b - Off0);
                        s.more = 3'd2;
                    end
                end
                default: begin
                    if (b <= ShortLimit) begin
                        s.base = FieldBase0 + lo_byte(b);
                    end else if (b <= FieldMid) begin
                        s.base = FieldBase1 + lo_byte(b - Off0);
                    end else if (b <= MidLimit) begin
                        s.base = FieldBase0 + hi_byte(b - Off1);
                        s.more = 3'd2;
                    end else begin
                        s.base = FieldBase3 + hi_byte(b - Off2);
                        s.more = 3'd2;
                    end
                end
            endcase
        end
        return s;
    endfunction

endpackage

>>> src/compact_metadata_token_decoder_top.sv
// Compact metadata token decoder. Send one encoded byte per request on the
// slave side, with the token class (0 type, 1 string, 2 field) in tuser; the
// class is only looked at on the first byte of a token, and a first byte sent
// with class 3 is dropped. A token takes 2, 3 or 5 bytes depending on its
// first byte, and one decoded 32-bit token comes out on the master side after
// its last byte. One byte is accepted every cycle while the master side keeps
// up; the byte goes through an input register and one step of decode/add, and
// the token is then registered in the output register. A stalled master side
// holds the slave side once a token waits in the output register and the next
// byte waits in the input register.
module compact_metadata_token_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [cmtd_pkg::InDataW-1:0]  i_s_tdata,  // [7:0] data_byte
    input  logic [cmtd_pkg::KindW-1:0]    i_s_tuser,  // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [cmtd_pkg::OutDataW-1:0] o_m_tdata,  // [31:0] token, [34:32] bytes_used
    output logic [cmtd_pkg::KindW-1:0]    o_m_tuser   // [1:0] token_class
);

    cmtd_pkg::t_item in_item, held_item;
    cmtd_pkg::t_res  core_res, out_res;
    logic            held_valid, take, res_valid, out_ready;

    assign in_item.kind      = i_s_tuser;
    assign in_item.data_byte = i_s_tdata;

    cmtd_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    assign take = held_valid && out_ready;

    cmtd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    cmtd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (res_valid),
        .i_res     (core_res),
        .o_ready   (out_ready),
        .o_valid   (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_res     (out_res)
    );

    assign o_m_tdata = {5'b00000, out_res.bytes_used, out_res.token};
    assign o_m_tuser = out_res.token_class;

endmodule

>>> src/cmtd_in_reg.sv
module cmtd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cmtd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output cmtd_pkg::t_item o_item
);

    logic            r_valid;
    cmtd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> src/cmtd_core.sv
module cmtd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  cmtd_pkg::t_item i_item,
    output logic            o_res_valid,
    output cmtd_pkg::t_res  o_res
);

    logic [cmtd_pkg::UsedW-1:0]  r_bytes_left, n_bytes_left;
    logic [cmtd_pkg::TokW-1:0]   r_partial, n_partial;
    logic [cmtd_pkg::KindW-1:0]  r_class, n_class;
    logic [cmtd_pkg::UsedW-1:0]  r_total, n_total;
    logic [cmtd_pkg::ShiftW-1:0] r_shift, n_shift;

    cmtd_pkg::t_start            start;
    cmtd_pkg::t_class            kind;
    logic [cmtd_pkg::TokW-1:0]   sum;

    assign kind  = cmtd_pkg::t_class'(i_item.kind);
    assign start = cmtd_pkg::start_decode(kind, i_item.data_byte);
    assign sum   = r_partial + ({24'h000000, i_item.data_byte} << {r_shift, 3'b000});

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        n_class      = r_class;
        n_total      = r_total;
        n_shift      = r_shift;
        o_res_valid  = 1'b0;
        o_res.token       = sum;
        o_res.token_class = r_class;
        o_res.bytes_used  = r_total;
        if (i_take) begin
            if (r_bytes_left == '0) begin
                if (kind != cmtd_pkg::CLS_NONE) begin
                    n_partial    = start.base;
                    n_class      = i_item.kind;
                    n_bytes_left = start.more;
                    n_total      = start.more + 3'd1;
                    n_shift      = '0;
                end
            end else begin
                n_partial    = sum;
                n_bytes_left = r_bytes_left - 3'd1;
                if (r_bytes_left == 3'd1) begin
                    o_res_valid = 1'b1;
                    n_shift     = '0;
                end else begin
                    n_shift = r_shift + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_partial    <= '0;
            r_class      <= '0;
            r_total      <= '0;
            r_shift      <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_class      <= n_class;
            r_total      <= n_total;
            r_shift      <= n_shift;
        end
    end

endmodule

>>> src/cmtd_out_reg.sv
module cmtd_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cmtd_pkg::t_res i_res,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_m_ready,
    output cmtd_pkg::t_res o_res
);

    logic           r_valid;
    cmtd_pkg::t_res r_res;

    assign o_ready = !r_valid || i_m_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> tb/tb_compact_metadata_token_decoder_top.sv
module tb_compact_metadata_token_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned ByteTarget = 1700;
    localparam int unsigned QuietFrom  = 1400;

    typedef struct {
        logic [cmtd_pkg::TokW-1:0]  token;
        cmtd_pkg::t_class           token_class;
        logic [cmtd_pkg::UsedW-1:0] bytes_used;
    } t_tok;

    class token_scoreboard;
        logic [cmtd_pkg::UsedW-1:0]  bytes_left;
        logic [cmtd_pkg::TokW-1:0]   acc;
        cmtd_pkg::t_class            cls;
        logic [cmtd_pkg::UsedW-1:0]  total;
        logic [cmtd_pkg::ShiftW-1:0] shift;
        t_tok                        pending_tokens[$];
        int unsigned                 errors;

        function new();
            bytes_left = '0;
            acc        = '0;
            cls        = cmtd_pkg::CLS_TYPE;
            total      = '0;
            shift      = '0;
            errors     = 0;
        endfunction

        // called for every accepted request on the slave side
        function void note_byte(cmtd_pkg::t_class k, logic [cmtd_pkg::ByteW-1:0] b);
            logic [cmtd_pkg::TokW-1:0]  base;
            logic [cmtd_pkg::UsedW-1:0] more;
            t_tok                       t;
            if (bytes_left == 0) begin
                if (k == cmtd_pkg::CLS_NONE) begin
                    return;
                end
                more = 3'd1;
                base = '0;
                if (b == 8'hFF) begin
                    more = 3'd4;
                end else begin
                    case (k)
                        cmtd_pkg::CLS_TYPE: begin
                            if (b <= 8'hBF) begin
                                base = cmtd_pkg::TypeBase0 + (32'(b) << 8);
                            end else if (b <= 8'hEF) begin
                                base = cmtd_pkg::TypeBase1 + (32'(b - 8'hC0) << 8);
                            end else begin
                                base = cmtd_pkg::TypeBase2 + (32'(b - 8'hF0) << 8);
                            end
                        end
                        cmtd_pkg::CLS_STRING: begin
                            if (b <= 8'hBF) begin
                                base = cmtd_pkg::StrBase0 + (32'(b) << 8);
                            end else begin
                                base = cmtd_pkg::StrBase1 + (32'(b - 8'hC0) << 16);
                                more = 3'd2;
                            end
                        end
                        default: begin
                            if (b <= 8'hBF) begin
                                base = cmtd_pkg::FieldBase0 + (32'(b) << 8);
                            end else if (b <= 8'hDF) begin
                                base = cmtd_pkg::FieldBase1 + (32'(b - 8'hC0) << 8);
                            end else if (b <= 8'hEF) begin
                                base = cmtd_pkg::FieldBase0 + (32'(b - 8'hE0) << 16);
                                more = 3'd2;
                            end else begin
                                base = cmtd_pkg::FieldBase3 + (32'(b - 8'hF0) << 16);
                                more = 3'd2;
                            end
                        end
                    endcase
                end
                acc        = base;
                cls        = k;
                bytes_left = more;
                total      = more + 3'd1;
                shift      = '0;
                return;
            end
            acc        = acc + (32'(b) << (8 * shift));
            shift      = shift + 2'd1;
            bytes_left = bytes_left - 3'd1;
            if (bytes_left == 0) begin
                t.token       = acc;
                t.token_class = cls;
                t.bytes_used  = total;
                pending_tokens = {pending_tokens, t};
                shift = '0;
            end
        endfunction

        function void check_token(logic [cmtd_pkg::OutDataW-1:0] tdata,
                                  logic [cmtd_pkg::KindW-1:0] tuser);
            t_tok e;
            if (pending_tokens.size() == 0) begin
                $error("token: none expected, got %h", tdata[31:0]);
                errors++;
                return;
            end
            e = pending_tokens.pop_front();
            if (tdata[31:0] !== e.token) begin
                $error("token: expected %h, got %h", e.token, tdata[31:0]);
                errors++;
            end
            if (tuser !== e.token_class) begin
                $error("token_class: expected %0d, got %0d", e.token_class, tuser);
                errors++;
            end
            if (tdata[34:32] !== e.bytes_used) begin
                $error("bytes_used: expected %0d, got %0d", e.bytes_used, tdata[34:32]);
                errors++;
            end
        endfunction

        function void drain_check();
            if (pending_tokens.size() != 0) begin
                $error("%0d expected tokens never came out", pending_tokens.size());
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [cmtd_pkg::InDataW-1:0]  i_s_tdata;
    logic [cmtd_pkg::KindW-1:0]    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [cmtd_pkg::OutDataW-1:0] o_m_tdata;
    logic [cmtd_pkg::KindW-1:0]    o_m_tuser;

    token_scoreboard sb = new();
    bit          quiet = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;

    compact_metadata_token_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_token(o_m_tdata, o_m_tuser);
        end
    end

    initial begin
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // entered and left at a falling edge
    task automatic push_byte(input cmtd_pkg::t_class k,
                             input logic [cmtd_pkg::ByteW-1:0] b);
        if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= k;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(k, b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // following bytes come from tail, lowest byte first, with a random kind
    task automatic send_token(input cmtd_pkg::t_class k,
                              input logic [cmtd_pkg::ByteW-1:0] first,
                              input logic [31:0] tail);
        int i;
        i = 0;
        push_byte(k, first);
        while (sb.bytes_left != 0) begin
            push_byte(cmtd_pkg::t_class'($urandom_range(0, 3)), tail[8*i +: 8]);
            i++;
        end
    endtask

    function automatic logic [cmtd_pkg::ByteW-1:0] pick_first();
        logic [cmtd_pkg::ByteW-1:0] edges[10] = '{8'h00, 8'hBF, 8'hC0, 8'hDF, 8'hE0,
                                                  8'hEF, 8'hF0, 8'hFE, 8'hFF, 8'h01};
        case ($urandom_range(0, 5))
            0: return edges[$urandom_range(0, 9)];
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] tail;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_token(cmtd_pkg::CLS_TYPE,   8'h00, 32'h0000_0000);
        send_token(cmtd_pkg::CLS_TYPE,   8'hBF, 32'h0000_00FF);
        send_token(cmtd_pkg::CLS_TYPE,   8'hC0, 32'h0000_00A5);
        send_token(cmtd_pkg::CLS_TYPE,   8'hF0, 32'h0000_005A);
        send_token(cmtd_pkg::CLS_STRING, 8'hBF, 32'h0000_0080);
        send_token(cmtd_pkg::CLS_STRING, 8'hFE, 32'h0000_FFFF);
        send_token(cmtd_pkg::CLS_FIELD,  8'hDF, 32'h0000_0001);
        send_token(cmtd_pkg::CLS_FIELD,  8'hE0, 32'h0000_8001);
        send_token(cmtd_pkg::CLS_FIELD,  8'hFE, 32'h0000_FFFF);
        push_byte(cmtd_pkg::CLS_NONE, 8'h7E);
        send_token(cmtd_pkg::CLS_FIELD,  8'hFF, 32'hFFFF_FFFF);

        while (bytes_sent < ByteTarget) begin
            if (bytes_sent % 100 < 5) begin
                src_idle_pct = $urandom_range(0, 2) * 20;
                snk_idle_pct = $urandom_range(0, 2) * 25;
            end
            quiet = (bytes_sent >= QuietFrom);
            if ($urandom_range(0, 11) == 0) begin
                push_byte(cmtd_pkg::CLS_NONE, 8'($urandom));
            end
            tail = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
            send_token(cmtd_pkg::t_class'($urandom_range(0, 2)), pick_first(), tail);
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.drain_check();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
